// ----- hw/rtl/overwrite_oldest_trace_buffer_unit_assert.svh -----
// Assertion macros for the trace buffer checks.
// Used by the top level; expects clk and rst_n in scope.
`ifndef OVERWRITE_OLDEST_TRACE_BUFFER_UNIT_ASSERT_SVH
`define OVERWRITE_OLDEST_TRACE_BUFFER_UNIT_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent
`define OTB_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("otb check failed in the same cycle");

// Consequent checked in the cycle after the antecedent
`define OTB_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("otb check failed one cycle later");

`endif

// ----- hw/rtl/otb_pkg.sv -----
// Shared types and constants for the overwriting trace buffer.
// No dependencies.
`timescale 1ns / 1ps

package otb_pkg;

  // Buffer geometry
  localparam int DEPTH  = 128;
  localparam int IDX_W  = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int PEND_W = 8;
  localparam int DROP_W = 32;

  // Operation codes
  typedef enum logic [1:0] {
    OP_RECORD = 2'd0,
    OP_POP    = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_RESET  = 2'd3
  } op_t;

  // One stored event
  typedef struct packed {
    logic [31:0] time_us;
    logic [7:0]  tag;
    logic [7:0]  arg;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // Store access for one item
  typedef struct packed {
    logic             we;
    logic             re;
    logic [IDX_W-1:0] addr;
  } ram_cmd_t;

  // Result status for one item
  typedef struct packed {
    logic              hit;
    logic [PEND_W-1:0] pending;
    logic [DROP_W-1:0] dropped;
  } status_t;

endpackage

// ----- hw/rtl/otb_ram.sv -----
// Generic single-port RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps

module otb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write and registered read share the address
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[addr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- hw/rtl/otb_ctrl.sv -----
// Ring pointer, fill count and drop counter for the trace buffer.
// Depends on otb_pkg.
`timescale 1ns / 1ps

module otb_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              accept,
  input  otb_pkg::op_t      op,
  output otb_pkg::ram_cmd_t cmd,
  output otb_pkg::status_t  status
);
  import otb_pkg::*;

  localparam int SUM_W = CNT_W + 1;

  logic [IDX_W-1:0]  oldest_r, oldest_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [DROP_W-1:0] drops_r, drops_nxt;

  logic              full, empty;
  logic [IDX_W-1:0]  oldest_inc;
  logic [SUM_W-1:0]  tail_sum;
  logic [IDX_W-1:0]  tail;

  // Pointer arithmetic
  assign full       = (count_r == CNT_W'(DEPTH));
  assign empty      = (count_r == '0);
  assign oldest_inc = (oldest_r == IDX_W'(DEPTH - 1)) ? '0 : oldest_r + 1'b1;
  assign tail_sum   = SUM_W'(oldest_r) + SUM_W'(count_r);
  assign tail       = (tail_sum >= SUM_W'(DEPTH)) ? IDX_W'(tail_sum - SUM_W'(DEPTH))
                                                  : IDX_W'(tail_sum);

  // Next state and store command
  always_comb begin
    oldest_nxt = oldest_r;
    count_nxt  = count_r;
    drops_nxt  = drops_r;
    cmd.we     = 1'b0;
    cmd.re     = 1'b0;
    cmd.addr   = oldest_r;
    status.hit = 1'b0;
    unique case (op)
      OP_RECORD: begin
        cmd.we = accept;
        if (full) begin
          // overwrite the oldest slot and advance past it
          oldest_nxt = oldest_inc;
          drops_nxt  = drops_r + 1'b1;
          cmd.addr   = oldest_r;
        end else begin
          count_nxt = count_r + 1'b1;
          cmd.addr  = tail;
        end
      end
      OP_POP: begin
        if (!empty) begin
          cmd.re     = accept;
          status.hit = 1'b1;
          oldest_nxt = oldest_inc;
          count_nxt  = count_r - 1'b1;
        end
      end
      OP_CLEAR: begin
        drops_nxt = '0;
      end
      OP_RESET: begin
        oldest_nxt = '0;
        count_nxt  = '0;
        drops_nxt  = '0;
      end
      default: begin
        drops_nxt = drops_r;
      end
    endcase
    status.pending = PEND_W'(count_nxt);
    status.dropped = drops_nxt;
  end

  // State registers, updated per accepted item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oldest_r <= '0;
      count_r  <= '0;
      drops_r  <= '0;
    end else if (accept) begin
      oldest_r <= oldest_nxt;
      count_r  <= count_nxt;
      drops_r  <= drops_nxt;
    end
  end

endmodule

// ----- hw/rtl/overwrite_oldest_trace_buffer_unit.sv -----
// Latency: a result is valid in the cycle after its item is accepted.
// Throughput: one item per cycle unless a waiting result is stalled; the single
// store port does either the record write or the pop read of one item per cycle.
// Reset clears the pointer, fill count, drop counter and result register;
// the event store is not cleared and needs no clearing pass.
`timescale 1ns / 1ps

module overwrite_oldest_trace_buffer_unit (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [1:0]                  in_operation,
  input  logic [31:0]                 in_time_us,
  input  logic [7:0]                  in_tag,
  input  logic [7:0]                  in_arg,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        out_valid_res,
  output logic [31:0]                 out_out_time_us,
  output logic [7:0]                  out_out_tag,
  output logic [7:0]                  out_out_arg,
  output logic [otb_pkg::PEND_W-1:0]  out_pending,
  output logic [otb_pkg::DROP_W-1:0]  out_dropped
);
  import otb_pkg::*;

  `include "overwrite_oldest_trace_buffer_unit_assert.svh"

  logic     accept;
  op_t      op;
  ram_cmd_t cmd;
  status_t  status;
  entry_t   wr_entry;
  entry_t   rd_entry;
  logic [ENTRY_W-1:0] rd_bits;

  logic     res_valid_r;
  status_t  res_status_r;

  logic     acc_reset;
  logic     acc_clear;
  logic     res_cleared;

  // Input handshake: hold off while a result waits downstream
  assign in_stall = res_valid_r & out_stall;
  assign accept   = in_valid & ~in_stall;
  assign op       = op_t'(in_operation);

  assign wr_entry.time_us = in_time_us;
  assign wr_entry.tag     = in_tag;
  assign wr_entry.arg     = in_arg;

  otb_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .accept (accept),
    .op     (op),
    .cmd    (cmd),
    .status (status)
  );

  otb_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (cmd.we),
    .re    (cmd.re),
    .addr  (cmd.addr),
    .wdata (wr_entry),
    .rdata (rd_bits)
  );

  assign rd_entry = entry_t'(rd_bits);

  // Result register; store read data lands alongside it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_valid_r <= 1'b0;
    end else if (!in_stall) begin
      res_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_status_r <= '0;
    end else if (accept) begin
      res_status_r <= status;
    end
  end

  // Result fields; event fields read zero unless a pop hit
  assign out_valid       = res_valid_r;
  assign out_valid_res   = res_status_r.hit;
  assign out_out_time_us = res_status_r.hit ? rd_entry.time_us : '0;
  assign out_out_tag     = res_status_r.hit ? rd_entry.tag : '0;
  assign out_out_arg     = res_status_r.hit ? rd_entry.arg : '0;
  assign out_pending     = res_status_r.pending;
  assign out_dropped     = res_status_r.dropped;

  // Checks
  assign acc_reset   = accept && (op == OP_RESET);
  assign acc_clear   = accept && (op == OP_CLEAR);
  assign res_cleared = out_valid && (out_dropped == '0) && !out_valid_res;

  `OTB_ASSERT_SAME(a_pending_bound, out_valid, out_pending <= PEND_W'(DEPTH))
  `OTB_ASSERT_NEXT(a_reset_empties, acc_reset, res_cleared && (out_pending == '0))
  `OTB_ASSERT_NEXT(a_clear_drops, acc_clear, res_cleared)

endmodule
